/* rtl/core/sopf_pkg.sv */
// Package: shared types, action codes and constants for the string overlap unit.
`timescale 1ns / 1ps
package sopf_pkg;

    localparam int LEN_W       = 8;
    localparam int MAX_LEN_DEF = 128;

    typedef enum logic [1:0] {
        ACT_REF_START   = 2'd0,
        ACT_REF_APPEND  = 2'd1,
        ACT_CAND_START  = 2'd2,
        ACT_CAND_APPEND = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] symbol;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] overlap;
        logic [LEN_W-1:0] residual;
        logic             overflow;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FALL,
        ST_FALL_GET,
        ST_LOOKUP,
        ST_CMP
    } state_t;

endpackage

/* rtl/core/string_overlap_by_prefix_function_unit.sv */
// Suffix-prefix overlap unit: border table build and candidate matching.
//
// Usage: drive cmd and raise start; a command beat is taken on a clock edge
// with start high and busy low. Reference actions load one byte each and
// extend the border table; candidate actions stream one byte through the
// matcher. A candidate beat with last set gives one result on result,
// marked by done for exactly one cycle; the receiver cannot hold it off.
// Per beat: a reference start, an append to an empty reference, a
// truncated byte or a dropped candidate byte completes at the accepting
// edge (busy stays low). Any other beat holds busy while it walks
// LOOKUP/CMP pairs, one pair per compare (at least one), preceded by
// FALL and FALL_GET for the border fetch that every reference append
// and a full-match candidate byte begin with; each compare follows a
// read of the character and border memories, so the failure-link walk
// sets the busy time. The result strobe is registered: it comes in the
// cycle after the final compare (or after the accepting edge of a
// dropped byte), in which a new beat may already be taken.
// Reset clears lengths, match state and flags; the string memories are
// not cleared and need no clearing pass, as only written entries are read.
`timescale 1ns / 1ps
module string_overlap_by_prefix_function_unit #(
    parameter int MAX_LEN = sopf_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sopf_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output sopf_pkg::result_t result
);
    import sopf_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

    logic [LEN_W-1:0] ref_mem [MAX_LEN];
    logic [LEN_W-1:0] bor_mem [MAX_LEN];

    state_t state_reg, state_next;
    logic [LEN_W-1:0] ref_length_reg, ref_length_next;
    logic [LEN_W-1:0] match_reg, match_next;
    logic [LEN_W-1:0] cand_length_reg, cand_length_next;
    logic ovf_reg, ovf_next;
    logic cand_ovf_reg, cand_ovf_next;
    logic done_reg, done_next;
    result_t result_reg, result_next;

    logic [LEN_W-1:0] t_reg, t_next;
    logic [7:0] sym_reg, sym_next;
    logic last_reg, last_next;
    logic is_cand_reg, is_cand_next;

    logic [LEN_W-1:0] rd_char_reg;
    logic [LEN_W-1:0] rd_border_reg;

    logic ref_we;
    logic [AW-1:0] ref_wa;
    logic bor_we;
    logic [AW-1:0] bor_wa;
    logic [LEN_W-1:0] bor_wd;
    logic [LEN_W-1:0] t_less1;

    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] c_len;
    logic [LEN_W-1:0] m_len;
    logic [LEN_W-1:0] t_init;
    logic [LEN_W-1:0] t_fin;
    logic [LEN_W-1:0] emit_m;
    logic emit;
    logic [LEN_W-1:0] emit_ov;

    assign t_less1 = t_reg - 1'b1;

    // single write / single registered read per memory
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= sym_next;
        end
        if (bor_we)
        begin
            bor_mem[bor_wa] <= bor_wd;
        end
        rd_char_reg   <= ref_mem[t_reg[AW-1:0]];
        rd_border_reg <= bor_mem[t_less1[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ref_length_reg  <= '0;
            match_reg       <= '0;
            cand_length_reg <= '0;
            ovf_reg         <= 1'b0;
            cand_ovf_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ref_length_reg  <= ref_length_next;
            match_reg       <= match_next;
            cand_length_reg <= cand_length_next;
            ovf_reg         <= ovf_next;
            cand_ovf_reg    <= cand_ovf_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        is_cand_reg <= is_cand_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        ref_length_next  = ref_length_reg;
        match_next       = match_reg;
        cand_length_next = cand_length_reg;
        ovf_next         = ovf_reg;
        cand_ovf_next    = cand_ovf_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        t_next           = t_reg;
        sym_next         = sym_reg;
        last_next        = last_reg;
        is_cand_next     = is_cand_reg;
        ref_we           = 1'b0;
        ref_wa           = ref_length_reg[AW-1:0];
        bor_we           = 1'b0;
        bor_wa           = ref_length_reg[AW-1:0];
        bor_wd           = '0;
        n_len            = ref_length_reg;
        c_len            = cand_length_reg;
        m_len            = match_reg;
        t_init           = '0;
        t_fin            = t_reg;
        emit             = 1'b0;
        emit_m           = match_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sym_next     = cmd.symbol;
                    last_next    = cmd.last;
                    is_cand_next = cmd.action[1];
                    case (cmd.action)
                        ACT_REF_START, ACT_REF_APPEND:
                        begin
                            if (cmd.action == ACT_REF_START)
                            begin
                                n_len      = '0;
                                ovf_next   = 1'b0;
                                match_next = '0;
                            end
                            ref_length_next = n_len;
                            if (n_len >= MAX_L)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ref_we = 1'b1;
                                ref_wa = n_len[AW-1:0];
                                if (n_len == '0)
                                begin
                                    bor_we          = 1'b1;
                                    bor_wa          = '0;
                                    bor_wd          = '0;
                                    ref_length_next = LEN_W'(1);
                                end
                                else
                                begin
                                    // border of the previous prefix seeds the walk
                                    t_next     = n_len;
                                    state_next = ST_FALL;
                                end
                            end
                        end
                        ACT_CAND_START, ACT_CAND_APPEND:
                        begin
                            if (cmd.action == ACT_CAND_START)
                            begin
                                c_len         = '0;
                                m_len         = '0;
                                cand_ovf_next = 1'b0;
                                match_next    = '0;
                            end
                            cand_length_next = c_len;
                            if (c_len >= MAX_L)
                            begin
                                cand_ovf_next = 1'b1;
                                emit          = cmd.last;
                                emit_m        = m_len;
                            end
                            else
                            begin
                                cand_length_next = c_len + 1'b1;
                                t_init = (m_len > ref_length_reg) ? ref_length_reg : m_len;
                                t_next = t_init;
                                // full match: drop to the whole-reference border first
                                if (t_init != '0 && t_init == ref_length_reg)
                                begin
                                    state_next = ST_FALL;
                                end
                                else
                                begin
                                    state_next = ST_LOOKUP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FALL:
            begin
                state_next = ST_FALL_GET;
            end
            ST_FALL_GET:
            begin
                t_next     = rd_border_reg;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (t_reg != '0 && rd_char_reg != sym_reg)
                begin
                    t_next     = rd_border_reg;
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    t_fin = t_reg;
                    if (t_reg < ref_length_reg && rd_char_reg == sym_reg)
                    begin
                        t_fin = t_reg + 1'b1;
                    end
                    if (!is_cand_reg)
                    begin
                        bor_we          = 1'b1;
                        bor_wa          = ref_length_reg[AW-1:0];
                        bor_wd          = t_fin;
                        ref_length_next = ref_length_reg + 1'b1;
                    end
                    else
                    begin
                        match_next = t_fin;
                        emit       = last_reg;
                        emit_m     = t_fin;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        emit_ov = (emit_m > cand_length_next) ? cand_length_next : emit_m;
        if (emit)
        begin
            done_next            = 1'b1;
            result_next.overlap  = emit_ov;
            result_next.residual = cand_length_next - emit_ov;
            result_next.overflow = ovf_next | cand_ovf_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE))
        else $error("result strobe while sequencer active");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= ref_length_reg)
        else $error("match length past reference length");

    a_ref_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ref_length_reg <= MAX_L && cand_length_reg <= MAX_L)
        else $error("string length past limit");

    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (t_reg <= ref_length_reg))
        else $error("lookup index past reference");

    a_res_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.overlap <= cand_length_reg))
        else $error("overlap exceeds candidate length");

endmodule
